>>> hw/rtl/admittance_controller_4axis_defines.svh
// assertion macros shared by the admittance controller rtl
`ifndef ADMITTANCE_CONTROLLER_4AXIS_DEFINES_SVH
`define ADMITTANCE_CONTROLLER_4AXIS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define AC4_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define AC4_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AC4_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define AC4_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hw/rtl/admc_pkg.sv
package admc_pkg;

    localparam int DEFAULT_AXIS_COUNT = 4;
    localparam int MAX_AXES           = 4;

    localparam int FIX_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int DT_W       = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // shared multiplier: signed a, unsigned b
    localparam int MUL_A_W = 44;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = 68;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd4;

    // item operations
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SET    = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [1:0]              axis_select;
        logic signed [FIX_W-1:0] force_axis0;
        logic signed [FIX_W-1:0] force_axis1;
        logic signed [FIX_W-1:0] force_axis2;
        logic signed [FIX_W-1:0] force_axis3;
        logic signed [FIX_W-1:0] load_position;
        logic signed [FIX_W-1:0] load_target;
    } t_item;

    typedef struct packed {
        logic signed [FIX_W-1:0] position_axis0;
        logic signed [FIX_W-1:0] position_axis1;
        logic signed [FIX_W-1:0] position_axis2;
        logic signed [FIX_W-1:0] position_axis3;
        logic signed [FIX_W-1:0] velocity_axis0;
        logic signed [FIX_W-1:0] velocity_axis1;
        logic signed [FIX_W-1:0] velocity_axis2;
        logic signed [FIX_W-1:0] velocity_axis3;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] inv_mass;
        logic [CFG_DATA_W-1:0] damping;
        logic [CFG_DATA_W-1:0] stiffness;
        logic [CFG_DATA_W-1:0] vel_limit;
        logic [DT_W-1:0]       time_step;
    } t_cfg_regs;

endpackage

>>> hw/rtl/admc_channels.sv
interface admc_item_if;
    logic           valid;
    logic           ready;
    admc_pkg::t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface admc_result_if;
    logic             valid;
    logic             ready;
    admc_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface admc_cfg_if;
    logic                valid;
    logic                ready;
    admc_pkg::t_cfg_write payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/admittance_controller_4axis.sv
// four-axis admittance controller (mass-spring-damper law with velocity clamp)
// channels: i_item takes one beat per item (update with four forces, or set of
// one axis's position and target); o_result gives one beat per item with all
// positions and velocities; i_cfg writes gains, limits and dt, one register a
// beat, always ready, and must only be used while the block is idle.
// an update runs axis by axis through one shared 44x24 multiplier under a
// phase sequencer; an update and a set item both pass through the done
// state, from which the result is loaded into the output register.
// one item is in flight at a time: i_item.ready is high only when the
// sequencer is idle, so the next input beat is taken only once the result
// of the item before has been loaded into the output register.
// reset clears positions, velocities, targets, all config registers and the output
// valid. if the receiver stalls, the finished result waits in the output
// register while the next item is taken and worked on; that item then waits
// in the done state, with the input not ready, until the beat is taken.
`include "admittance_controller_4axis_defines.svh"

module admittance_controller_4axis #(
    parameter int AXIS_COUNT = admc_pkg::DEFAULT_AXIS_COUNT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    admc_item_if.sink      i_item,
    admc_result_if.source  o_result,
    admc_cfg_if.sink       i_cfg
);

    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // per-axis phases
    localparam logic [3:0] PH_DV   = 4'd0;  // damping * velocity
    localparam logic [3:0] PH_SE   = 4'd1;  // stiffness * error, subtract damping term
    localparam logic [3:0] PH_SUM  = 4'd2;  // add stiffness term
    localparam logic [3:0] PH_IM   = 4'd3;  // (sum >> 8) * inverse mass
    localparam logic [3:0] PH_ACC  = 4'd4;  // acceleration, saturated to 40 bits
    localparam logic [3:0] PH_ADT  = 4'd5;  // acceleration * dt
    localparam logic [3:0] PH_VEL  = 4'd6;  // velocity update and clamp
    localparam logic [3:0] PH_VDT  = 4'd7;  // velocity * dt
    localparam logic [3:0] PH_POS  = 4'd8;  // position update

    localparam int FW = admc_pkg::FIX_W;
    localparam int GW = admc_pkg::GAIN_W;

    admc_pkg::t_cfg_regs cfg;

    logic [1:0]          r_state;
    logic [3:0]          r_phase;
    logic [AW-1:0]       r_axis;

    logic signed [FW-1:0] r_pos   [AXIS_COUNT];
    logic signed [FW-1:0] r_vel   [AXIS_COUNT];
    logic signed [FW-1:0] r_tgt   [AXIS_COUNT];
    logic signed [FW-1:0] r_force [AXIS_COUNT];

    logic signed [51:0]  r_sum;
    logic signed [39:0]  r_acc;

    logic                r_out_valid;
    admc_pkg::t_result   r_out;

    logic signed [admc_pkg::MUL_A_W-1:0] mul_a;
    logic        [admc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [admc_pkg::MUL_P_W-1:0] prod;
    logic                                mul_en;

    logic [GW-1:0]       inv_mass;
    logic [GW-1:0]       damping;
    logic [GW-1:0]       stiffness;
    logic [GW-1:0]       vel_limit;

    logic signed [FW-1:0] pos_cur;
    logic signed [FW-1:0] vel_cur;
    logic signed [FW-1:0] tgt_cur;
    logic signed [FW-1:0] force_cur;
    logic signed [FW:0]   err;

    logic signed [FW:0]   lim_x;
    logic signed [FW:0]   neg_lim_x;
    logic signed [FW:0]   vel_cur_x;
    logic signed [FW:0]   vel_sat_x;
    logic signed [43:0]   step_inc;
    logic signed [44:0]   vel_sum;
    logic signed [44:0]   pos_sum;
    logic signed [FW-1:0] vel_sat;
    logic signed [FW-1:0] n_vel;
    logic signed [FW-1:0] n_pos;
    logic signed [39:0]   acc_sat;

    logic                item_acc;
    logic                set_hit;
    logic [AW-1:0]       set_idx;
    logic                last_axis;
    logic                load_out;

    logic signed [FW-1:0] in_force [admc_pkg::MAX_AXES];
    logic signed [FW-1:0] pos_view [admc_pkg::MAX_AXES];
    logic signed [FW-1:0] vel_view [admc_pkg::MAX_AXES];

    // saturate a 45-bit sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [44:0] x);
        logic signed [31:0] res;
        if ((x[44:31] == '0) || (x[44:31] == '1)) begin
            res = x[31:0];
        end else if (x[44]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7fff_ffff;
        end
        return res;
    endfunction

    // saturate a 60-bit value to 40 bits
    function automatic logic signed [39:0] sat40(input logic signed [59:0] x);
        logic signed [39:0] res;
        if ((x[59:39] == '0) || (x[59:39] == '1)) begin
            res = x[39:0];
        end else if (x[59]) begin
            res = 40'sh80_0000_0000;
        end else begin
            res = 40'sh7f_ffff_ffff;
        end
        return res;
    endfunction

    admc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (cfg)
    );

    admc_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // handshake
    assign i_item.ready     = (r_state == ST_IDLE);
    assign item_acc         = i_item.valid && (r_state == ST_IDLE);
    assign set_hit          = (i_item.payload.axis_select < AXIS_COUNT);
    assign set_idx          = i_item.payload.axis_select[AW-1:0];
    assign last_axis        = (r_axis == AW'(AXIS_COUNT - 1));
    assign load_out         = (r_state == ST_DONE) && (!r_out_valid || o_result.ready);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // gains of the axis being worked on
    assign inv_mass  = cfg.inv_mass[GW*r_axis +: GW];
    assign damping   = cfg.damping[GW*r_axis +: GW];
    assign stiffness = cfg.stiffness[GW*r_axis +: GW];
    assign vel_limit = cfg.vel_limit[GW*r_axis +: GW];

    assign pos_cur   = r_pos[r_axis];
    assign vel_cur   = r_vel[r_axis];
    assign tgt_cur   = r_tgt[r_axis];
    assign force_cur = r_force[r_axis];
    assign err       = {tgt_cur[FW-1], tgt_cur} - {pos_cur[FW-1], pos_cur};

    // shared multiplier operand select
    assign mul_en = (r_state == ST_RUN);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_phase)
            PH_DV: begin
                mul_a = {{12{vel_cur[FW-1]}}, vel_cur};
                mul_b = {8'd0, damping};
            end
            PH_SE: begin
                mul_a = {{11{err[FW]}}, err};
                mul_b = {8'd0, stiffness};
            end
            PH_IM: begin
                mul_a = r_sum[51:8];
                mul_b = {8'd0, inv_mass};
            end
            PH_ADT: begin
                mul_a = {{4{r_acc[39]}}, r_acc};
                mul_b = cfg.time_step;
            end
            PH_VDT: begin
                mul_a = {{12{vel_cur[FW-1]}}, vel_cur};
                mul_b = cfg.time_step;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // integration; the product register holds x*dt, so >> 24 is a slice
    assign acc_sat   = sat40(prod[67:8]);
    assign step_inc  = prod[67:24];
    assign vel_sum   = {{13{vel_cur[FW-1]}}, vel_cur} + {step_inc[43], step_inc};
    assign vel_sat   = sat32(vel_sum);
    assign vel_sat_x = {vel_sat[FW-1], vel_sat};
    assign vel_cur_x = {vel_cur[FW-1], vel_cur};
    assign lim_x     = {9'd0, vel_limit, 8'd0};
    assign neg_lim_x = -lim_x;
    assign pos_sum   = {{13{pos_cur[FW-1]}}, pos_cur} + {step_inc[43], step_inc};
    assign n_pos     = sat32(pos_sum);

    // clamp to plus or minus the axis limit
    always_comb begin
        if (vel_sat_x > lim_x) begin
            n_vel = lim_x[FW-1:0];
        end else if (vel_sat_x < neg_lim_x) begin
            n_vel = neg_lim_x[FW-1:0];
        end else begin
            n_vel = vel_sat;
        end
    end

    assign in_force[0] = i_item.payload.force_axis0;
    assign in_force[1] = i_item.payload.force_axis1;
    assign in_force[2] = i_item.payload.force_axis2;
    assign in_force[3] = i_item.payload.force_axis3;

    // axes beyond the axis count read as zero
    for (genvar g = 0; g < admc_pkg::MAX_AXES; g++) begin : g_view
        if (g < AXIS_COUNT) begin : g_live
            assign pos_view[g] = r_pos[g];
            assign vel_view[g] = r_vel[g];
        end else begin : g_dead
            assign pos_view[g] = '0;
            assign vel_view[g] = '0;
        end
    end

    // control and axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_DV;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_tgt[i] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (item_acc) begin
                        if (i_item.payload.operation == admc_pkg::OP_SET) begin
                            if (set_hit) begin
                                r_pos[set_idx] <= i_item.payload.load_position;
                                r_tgt[set_idx] <= i_item.payload.load_target;
                                r_vel[set_idx] <= '0;
                            end
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RUN;
                            r_phase <= PH_DV;
                            r_axis  <= '0;
                        end
                    end
                end
                ST_RUN: begin
                    if (r_phase == PH_VEL) begin
                        r_vel[r_axis] <= n_vel;
                    end
                    if (r_phase == PH_POS) begin
                        r_pos[r_axis] <= n_pos;
                        r_phase       <= PH_DV;
                        if (last_axis) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_axis <= r_axis + AW'(1);
                        end
                    end else begin
                        r_phase <= r_phase + 4'd1;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (item_acc) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_force[i] <= in_force[i];
            end
        end
        if (r_state == ST_RUN) begin
            case (r_phase)
                PH_DV:   r_sum <= {{12{force_cur[FW-1]}}, force_cur, 8'd0};
                PH_SE:   r_sum <= r_sum - prod[51:0];
                PH_SUM:  r_sum <= r_sum + prod[51:0];
                PH_ACC:  r_acc <= acc_sat;
                default: ;
            endcase
        end
        if (load_out) begin
            r_out.position_axis0 <= pos_view[0];
            r_out.position_axis1 <= pos_view[1];
            r_out.position_axis2 <= pos_view[2];
            r_out.position_axis3 <= pos_view[3];
            r_out.velocity_axis0 <= vel_view[0];
            r_out.velocity_axis1 <= vel_view[1];
            r_out.velocity_axis2 <= vel_view[2];
            r_out.velocity_axis3 <= vel_view[3];
        end
    end

    // an update beat keeps the block busy for the next cycle
    `AC4_ASSERT_NXT(a_busy_after_update, i_clk, i_rst_n, item_acc && (i_item.payload.operation == admc_pkg::OP_UPDATE), !i_item.ready, "input ready right after an update beat")
    // the velocity just written respects the axis limit
    `AC4_ASSERT_IMP(a_vel_in_limit, i_clk, i_rst_n, (r_state == ST_RUN) && (r_phase == PH_VDT), (vel_cur_x <= lim_x) && (vel_cur_x >= neg_lim_x), "velocity outside its limit")
    // a result only appears after the sequencer has finished
    `AC4_ASSERT_IMP(a_result_after_done, i_clk, i_rst_n, $rose(o_result.valid), $past(r_state) == ST_DONE, "result valid without a finished item")
    // the axis counter never leaves the configured axes
    `AC4_ASSERT_IMP(a_axis_in_range, i_clk, i_rst_n, r_state == ST_RUN, r_axis <= AW'(AXIS_COUNT - 1), "axis counter beyond axis count")

endmodule

>>> hw/rtl/admc_mul.sv
module admc_mul (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [admc_pkg::MUL_A_W-1:0]    i_a,
    input  logic        [admc_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [admc_pkg::MUL_P_W-1:0]    o_p
);

    logic signed [admc_pkg::MUL_A_W+admc_pkg::MUL_B_W:0] full;

    // b is unsigned, so widen it by one zero bit
    assign full = i_a * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= full[admc_pkg::MUL_P_W-1:0];
        end
    end

endmodule

>>> hw/rtl/admc_cfg_regs.sv
module admc_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    admc_cfg_if.sink             i_cfg,
    output admc_pkg::t_cfg_regs  o_regs
);

    admc_pkg::t_cfg_regs r_regs;

    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                admc_pkg::REG_INV_MASS:  r_regs.inv_mass  <= i_cfg.payload.data;
                admc_pkg::REG_DAMPING:   r_regs.damping   <= i_cfg.payload.data;
                admc_pkg::REG_STIFFNESS: r_regs.stiffness <= i_cfg.payload.data;
                admc_pkg::REG_VEL_LIMIT: r_regs.vel_limit <= i_cfg.payload.data;
                admc_pkg::REG_TIME_STEP:
                    r_regs.time_step <= i_cfg.payload.data[admc_pkg::DT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> test/tb_admittance_controller_4axis.sv
module tb_admittance_controller_4axis;

    // cycles with no beat on any channel before the run is abandoned
    // (covers the long receiver hold-off, a whole update and random gaps)
    localparam int STALL_LIMIT = 4000;
    // receiver hold-off length, in cycles, once enough results have arrived
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 150;
    // long enough to cover a whole update with margin
    localparam int DRAIN_CYCLES = 60;
    localparam int GAP_PCT      = 38;

    // acceleration is held to a 40-bit signed range before integration
    localparam longint ACC_HI = (longint'(1) <<< 39) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< 39);
    localparam longint FIX_HI = 2147483647;
    localparam longint FIX_LO = -FIX_HI - 1;

    localparam int FIX_W    = admc_pkg::FIX_W;
    localparam int MAX_AXES = admc_pkg::MAX_AXES;

    logic i_clk;
    logic i_rst_n;

    admc_item_if   item_ch ();
    admc_result_if result_ch ();
    admc_cfg_if    cfg_ch ();

    admittance_controller_4axis DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // axis state and register copy mirrored by the predictor
    logic signed [FIX_W-1:0] axis_pos [MAX_AXES];
    logic signed [FIX_W-1:0] axis_vel [MAX_AXES];
    logic signed [FIX_W-1:0] axis_tgt [MAX_AXES];
    admc_pkg::t_cfg_regs     law_regs;

    admc_pkg::t_item   pending_items [$];
    admc_pkg::t_result expected_states [$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  quiet_cycles   = 0;
    int  send_gap_pct   = GAP_PCT;
    int  recv_gap_pct   = GAP_PCT;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  item_beat      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint sat32(input longint x);
        if (x > FIX_HI)
            return FIX_HI;
        if (x < FIX_LO)
            return FIX_LO;
        return x;
    endfunction

    // one item through the mass-spring-damper law, returns the state it leaves
    function automatic admc_pkg::t_result advance_axes(input admc_pkg::t_item it);
        longint            frc [MAX_AXES];
        longint            dt, err, sum, acc, v, lim;
        int                a;
        admc_pkg::t_result r;
        frc[0] = longint'(signed'(it.force_axis0));
        frc[1] = longint'(signed'(it.force_axis1));
        frc[2] = longint'(signed'(it.force_axis2));
        frc[3] = longint'(signed'(it.force_axis3));
        if (it.operation == admc_pkg::OP_SET) begin
            // set: load one axis, velocity cleared, forces ignored
            axis_pos[it.axis_select] = it.load_position;
            axis_tgt[it.axis_select] = it.load_target;
            axis_vel[it.axis_select] = '0;
        end else begin
            dt = longint'(law_regs.time_step);
            for (a = 0; a < MAX_AXES; a++) begin
                err = longint'(axis_tgt[a]) - longint'(axis_pos[a]);
                sum = frc[a] * 256
                    - longint'(law_regs.damping[16*a +: 16]) * longint'(axis_vel[a])
                    + longint'(law_regs.stiffness[16*a +: 16]) * err;
                // floor shifts: >>> on signed values rounds toward minus infinity
                acc = ((sum >>> 8) * longint'(law_regs.inv_mass[16*a +: 16])) >>> 8;
                if (acc > ACC_HI)
                    acc = ACC_HI;
                else if (acc < ACC_LO)
                    acc = ACC_LO;
                v   = sat32(longint'(axis_vel[a]) + ((acc * dt) >>> 24));
                lim = longint'(law_regs.vel_limit[16*a +: 16]) * 256;
                if (v > lim)
                    v = lim;
                else if (v < -lim)
                    v = -lim;
                axis_vel[a] = 32'(v);
                axis_pos[a] = 32'(sat32(longint'(axis_pos[a]) + ((v * dt) >>> 24)));
            end
        end
        r.position_axis0 = axis_pos[0];
        r.position_axis1 = axis_pos[1];
        r.position_axis2 = axis_pos[2];
        r.position_axis3 = axis_pos[3];
        r.velocity_axis0 = axis_vel[0];
        r.velocity_axis1 = axis_vel[1];
        r.velocity_axis2 = axis_vel[2];
        r.velocity_axis3 = axis_vel[3];
        return r;
    endfunction

    task automatic check_word(input string field, input logic [FIX_W-1:0] want,
                              input logic [FIX_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatch_count++;
        end
    endtask

    // monitor: sample every channel at the rising edge
    always @(posedge i_clk) begin
        item_beat <= item_ch.valid && item_ch.ready;
        if (i_rst_n) begin
            // register beat updates the predictor's copy of the registers
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.payload.index)
                    admc_pkg::REG_INV_MASS:  law_regs.inv_mass  = cfg_ch.payload.data;
                    admc_pkg::REG_DAMPING:   law_regs.damping   = cfg_ch.payload.data;
                    admc_pkg::REG_STIFFNESS: law_regs.stiffness = cfg_ch.payload.data;
                    admc_pkg::REG_VEL_LIMIT: law_regs.vel_limit = cfg_ch.payload.data;
                    admc_pkg::REG_TIME_STEP:
                        law_regs.time_step = cfg_ch.payload.data[admc_pkg::DT_W-1:0];
                    default: ;
                endcase
            end
            // each item beat gives exactly one expected result
            if (item_ch.valid && item_ch.ready)
                expected_states.push_back(advance_axes(item_ch.payload));
            // result beats are compared in order against the oldest expectation
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (expected_states.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatch_count++;
                end else begin
                    check_word("position_axis0", expected_states[0].position_axis0,
                               result_ch.payload.position_axis0);
                    check_word("position_axis1", expected_states[0].position_axis1,
                               result_ch.payload.position_axis1);
                    check_word("position_axis2", expected_states[0].position_axis2,
                               result_ch.payload.position_axis2);
                    check_word("position_axis3", expected_states[0].position_axis3,
                               result_ch.payload.position_axis3);
                    check_word("velocity_axis0", expected_states[0].velocity_axis0,
                               result_ch.payload.velocity_axis0);
                    check_word("velocity_axis1", expected_states[0].velocity_axis1,
                               result_ch.payload.velocity_axis1);
                    check_word("velocity_axis2", expected_states[0].velocity_axis2,
                               result_ch.payload.velocity_axis2);
                    check_word("velocity_axis3", expected_states[0].velocity_axis3,
                               result_ch.payload.velocity_axis3);
                    void'(expected_states.pop_front());
                end
            end
        end
        // watchdog on channel activity
        if ((cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready)
                || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** admittance_controller_4axis: FAILED **");
            $finish;
        end
    end

    // item driver: holds a beat until taken, then offers the next or idles
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (!item_ch.valid || item_beat) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                item_ch.payload <= pending_items.pop_front();
                item_ch.valid   <= 1'b1;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus one long hold-off so the block
    // fills and the sender sees its input stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            result_ch.ready <= 1'b0;
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    function automatic admc_pkg::t_item make_item(input logic op, input logic [1:0] sel,
            input logic [FIX_W-1:0] f0, input logic [FIX_W-1:0] f1,
            input logic [FIX_W-1:0] f2, input logic [FIX_W-1:0] f3,
            input logic [FIX_W-1:0] lp, input logic [FIX_W-1:0] lt);
        admc_pkg::t_item it;
        it.operation     = op;
        it.axis_select   = sel;
        it.force_axis0   = f0;
        it.force_axis1   = f1;
        it.force_axis2   = f2;
        it.force_axis3   = f3;
        it.load_position = lp;
        it.load_target   = lt;
        return it;
    endfunction

    // q16.16 word: rails, zero, moderate values and full-range noise
    function automatic logic [FIX_W-1:0] rand_fix();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4, 5: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [admc_pkg::GAIN_W-1:0] rand_gain();
        case ($urandom_range(9))
            0:          return '0;
            1:          return 16'hffff;
            2, 3, 4, 5: return 16'($urandom_range(16'h0200));
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic admc_pkg::t_cfg_regs random_regs();
        admc_pkg::t_cfg_regs c;
        int                  a;
        for (a = 0; a < MAX_AXES; a++) begin
            c.inv_mass[16*a +: 16]  = rand_gain();
            c.damping[16*a +: 16]   = rand_gain();
            c.stiffness[16*a +: 16] = rand_gain();
            c.vel_limit[16*a +: 16] = rand_gain();
        end
        case ($urandom_range(5))
            0:       c.time_step = '0;
            1:       c.time_step = 24'hff_ffff;
            default: c.time_step = 24'($urandom_range(24'h04_0000));
        endcase
        return c;
    endfunction

    task automatic write_reg(input logic [admc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [admc_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.payload.index <= idx;
        cfg_ch.payload.data  <= val;
        cfg_ch.valid         <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // dt beat carries random upper bits, which the block must drop
    task automatic write_law(input admc_pkg::t_cfg_regs c);
        write_reg(admc_pkg::REG_INV_MASS, c.inv_mass);
        write_reg(admc_pkg::REG_DAMPING, c.damping);
        write_reg(admc_pkg::REG_STIFFNESS, c.stiffness);
        write_reg(admc_pkg::REG_VEL_LIMIT, c.vel_limit);
        write_reg(admc_pkg::REG_TIME_STEP, {32'($urandom), 8'($urandom), c.time_step});
    endtask

    // wait until every queued item is taken and every result is back
    task automatic wait_drained();
        while (pending_items.size() != 0 || item_ch.valid || expected_states.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_items(input int n);
        admc_pkg::t_item it;
        repeat (n) begin
            it = make_item(($urandom_range(99) < 20) ? admc_pkg::OP_SET : admc_pkg::OP_UPDATE,
                           2'($urandom), rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                           rand_fix(), rand_fix());
            pending_items.push_back(it);
        end
    endtask

    initial begin
        admc_pkg::t_cfg_regs c;
        int                  p;

        // known levels from time zero
        i_rst_n         = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.payload  = '0;
        law_regs        = '0;
        for (p = 0; p < MAX_AXES; p++) begin
            axis_pos[p] = '0;
            axis_vel[p] = '0;
            axis_tgt[p] = '0;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: no acceleration, zero limit forces velocity to zero
        pending_items.push_back(make_item(admc_pkg::OP_UPDATE, 2'd3, 32'h7fff_ffff,
                                          32'h8000_0000, 32'h0, 32'hffff_ffff,
                                          $urandom, $urandom));
        pending_items.push_back(make_item(admc_pkg::OP_SET, 2'd0, $urandom, $urandom,
                                          $urandom, $urandom, 32'h7fff_ffff,
                                          32'h8000_0000));
        pending_items.push_back(make_item(admc_pkg::OP_UPDATE, 2'd1, 32'h7fff_ffff,
                                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                          $urandom, $urandom));
        settle();

        // every gain at full scale, longest step: drives the saturation paths
        c.inv_mass  = '1;
        c.damping   = '1;
        c.stiffness = '1;
        c.vel_limit = '1;
        c.time_step = '1;
        write_law(c);
        pending_items.push_back(make_item(admc_pkg::OP_SET, 2'd0, $urandom, $urandom,
                                          $urandom, $urandom, 32'h7fff_ffff,
                                          32'h8000_0000));
        pending_items.push_back(make_item(admc_pkg::OP_SET, 2'd1, $urandom, $urandom,
                                          $urandom, $urandom, 32'h8000_0000,
                                          32'h7fff_ffff));
        pending_items.push_back(make_item(admc_pkg::OP_SET, 2'd2, $urandom, $urandom,
                                          $urandom, $urandom, 32'h0, 32'h7fff_ffff));
        pending_items.push_back(make_item(admc_pkg::OP_SET, 2'd3, $urandom, $urandom,
                                          $urandom, $urandom, 32'hffff_ffff,
                                          32'h1234_5678));
        pending_items.push_back(make_item(admc_pkg::OP_UPDATE, 2'($urandom), 32'h7fff_ffff,
                                          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                          $urandom, $urandom));
        pending_items.push_back(make_item(admc_pkg::OP_UPDATE, 2'($urandom), 32'h8000_0000,
                                          32'h7fff_ffff, 32'h0, 32'h0, $urandom, $urandom));
        pending_items.push_back(make_item(admc_pkg::OP_UPDATE, 2'($urandom), 32'h0, 32'h0,
                                          32'h0, 32'h0, $urandom, $urandom));
        pending_items.push_back(make_item(admc_pkg::OP_SET, 2'd2, $urandom, $urandom,
                                          $urandom, $urandom, 32'h8000_0000,
                                          32'h7fff_ffff));
        pending_items.push_back(make_item(admc_pkg::OP_UPDATE, 2'($urandom), $urandom,
                                          $urandom, $urandom, $urandom, $urandom,
                                          $urandom));
        settle();

        // mixed lanes: axis 2 frozen (zero inverse mass) but still carrying its
        // old velocity, axis 3 with zero limit; then indexes past the last register
        c.inv_mass  = {16'h0100, 16'h0000, 16'h0080, 16'hffff};
        c.damping   = {16'h0000, 16'hffff, 16'h0200, 16'h0001};
        c.stiffness = {16'hffff, 16'h0000, 16'h0010, 16'h0100};
        c.vel_limit = {16'h0000, 16'h0040, 16'h7fff, 16'hffff};
        c.time_step = 24'h01_0000;
        write_law(c);
        for (p = admc_pkg::REG_TIME_STEP + 1; p < (1 << admc_pkg::CFG_IDX_W); p++)
            write_reg(admc_pkg::CFG_IDX_W'(p), {$urandom, $urandom});
        repeat (4)
            pending_items.push_back(make_item(admc_pkg::OP_UPDATE, 2'($urandom), rand_fix(),
                                              rand_fix(), rand_fix(), rand_fix(),
                                              $urandom, $urandom));
        pending_items.push_back(make_item(admc_pkg::OP_SET, 2'd1, $urandom, $urandom,
                                          $urandom, $urandom, 32'h0001_0000,
                                          32'hffff_0000));
        pending_items.push_back(make_item(admc_pkg::OP_UPDATE, 2'($urandom), 32'h8000_0000,
                                          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                          $urandom, $urandom));
        settle();

        // random phases, fresh register set each time; phase 2 runs without gaps
        for (p = 0; p < 5; p++) begin
            send_gap_pct = (p == 2) ? 0 : GAP_PCT;
            recv_gap_pct = (p == 2) ? 0 : GAP_PCT;
            write_law(random_regs());
            random_items(120);
            settle();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** admittance_controller_4axis: PASSED **");
        else
            $display("** admittance_controller_4axis: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/admc_pkg.sv
hw/rtl/admc_channels.sv
hw/rtl/admc_mul.sv
hw/rtl/admc_cfg_regs.sv
hw/rtl/admittance_controller_4axis.sv
test/tb_admittance_controller_4axis.sv
